@@ rtl/core/stencil_row_dedup_indexer_unit_macros.svh @@
// Assertion macros for the stencil row deduplicating indexer.
// Included by modules that carry concurrent checks; no dependencies.
`ifndef STENCIL_ROW_DEDUP_INDEXER_UNIT_MACROS_SVH
`define STENCIL_ROW_DEDUP_INDEXER_UNIT_MACROS_SVH
// check that a property holds on every clock edge outside reset
`define SRDI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check an implication from one condition to the next cycle
`define SRDI_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

@@ rtl/core/srdi_pkg.sv @@
// Shared types and constants for the stencil row deduplicating indexer.
// No dependencies.
`timescale 1ns / 1ps
package srdi_pkg;
    localparam int ENTRIES = 13;
    localparam int CELLS   = 13;

    typedef enum logic [1:0] {
        OP_ENTRY   = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_READOUT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ROW_LONG = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_WAIT,
        BK_COMPARE,
        BK_STORE,
        BK_EMIT,
        BK_READ,
        BK_CELL
    } bk_state_t;

    // command from front to back through the queue
    typedef struct packed {
        logic        is_readout;
        logic [7:0]  sel;
        logic        err;
        logic [1:0]  err_code;
        logic [4:0]  fill;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  set_index;
        logic        new_set;
        logic [1:0]  status;
        logic [8:0]  sets_in_use;
        logic [3:0]  position;
        logic [31:0] value;
        logic        last;
    } res_t;
endpackage

@@ rtl/core/srdi_front.sv @@
// Front end: decodes transactions, keeps the row buffer and row counter.
// Depends on srdi_pkg.
`timescale 1ns / 1ps
module srdi_front #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           operation,
    input  logic [15:0]          column_index,
    input  logic signed [31:0]   coefficient,
    input  logic                 entry_present,
    input  logic                 row_end,
    input  logic [7:0]           set_select,
    input  logic                 back_busy,
    output logic                 cmd_valid,
    output srdi_pkg::cmd_t       cmd,
    output logic                 clear,
    input  logic                 set_err,
    input  logic [1:0]           set_err_code,
    input  logic [3:0]           rd_idx,
    output logic [16:0]          rd_off,
    output logic [31:0]          rd_val
);
    import srdi_pkg::*;
    localparam int RW = $clog2(MAX_POINTS) + 1;

    logic [16:0] off_reg [ENTRIES];
    logic [31:0] val_reg [ENTRIES];
    logic [4:0]  fill_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]  err_reg;
    logic        acc;
    logic [16:0] off_new;

    assign full = back_busy;
    assign acc = push && !full;
    assign off_new = 17'({1'b0, column_index}) - 17'(row_reg);
    assign rd_off = off_reg[rd_idx];
    assign rd_val = val_reg[rd_idx];
    assign clear = acc && (op_t'(operation) == OP_ENTRY ? 1'b0 :
                           op_t'(operation) == OP_CLEAR);

    // issue row ends and readouts to the back end
    always_comb
    begin
        cmd = '0;
        cmd_valid = 1'b0;
        cmd.sel = set_select;
        cmd.err_code = err_reg;
        cmd.fill = fill_reg;
        if (acc && op_t'(operation) == OP_READOUT)
        begin
            cmd_valid = 1'b1;
            cmd.is_readout = 1'b1;
        end
        else if (acc && op_t'(operation) == OP_ENTRY && row_end)
        begin
            cmd_valid = 1'b1;
            cmd.err = (err_reg != ST_OK) ||
                      (entry_present && fill_reg >= 5'(ENTRIES)) ||
                      (fill_reg > 5'(ENTRIES));
            if (err_reg == ST_OK && cmd.err)
                cmd.err_code = ST_ROW_LONG;
            if (entry_present && fill_reg < 5'(ENTRIES))
                cmd.fill = fill_reg + 5'd1;
        end
    end

    // store entries, advance row
    always_ff @(posedge clk)
    begin
        if (acc && op_t'(operation) == OP_ENTRY && err_reg == ST_OK && entry_present &&
            fill_reg < 5'(ENTRIES))
        begin
            off_reg[fill_reg[3:0]] <= off_new;
            val_reg[fill_reg[3:0]] <= coefficient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            row_reg  <= '0;
            err_reg  <= ST_OK;
        end
        else
        begin
            if (set_err)
                err_reg <= set_err_code;
            if (clear)
            begin
                fill_reg <= '0;
                row_reg  <= '0;
                err_reg  <= ST_OK;
            end
            else if (acc && op_t'(operation) == OP_ENTRY && err_reg == ST_OK)
            begin
                if (row_end)
                begin
                    fill_reg <= '0;
                    row_reg  <= (row_reg >= RW'(MAX_POINTS - 1)) ? '0 : row_reg + 1'b1;
                end
                else if (entry_present)
                    fill_reg <= (fill_reg < 5'(ENTRIES)) ? fill_reg + 5'd1 : 5'(ENTRIES + 1);
            end
        end
    end
endmodule

@@ rtl/core/srdi_back.sv @@
// Back end: searches and appends sets, produces stencil readouts, result register.
// Depends on srdi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stencil_row_dedup_indexer_unit_macros.svh"
module srdi_back #(
    parameter int MAX_SETS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  srdi_pkg::cmd_t       cmd,
    input  logic                 clear,
    output logic                 busy,
    output logic                 set_err,
    output logic [1:0]           set_err_code,
    output logic [3:0]           rd_idx,
    input  logic [16:0]          rd_off,
    input  logic [31:0]          rd_val,
    input  logic [16:0]          column_stride,
    output logic                 res_valid,
    output srdi_pkg::res_t       res,
    input  logic                 res_pop
);
    import srdi_pkg::*;
    localparam int SW = $clog2(MAX_SETS);
    localparam int CW = $clog2(MAX_SETS + 1);
    localparam int DEPTH = MAX_SETS * ENTRIES;
    localparam int AW = $clog2(DEPTH);

    // set store memories
    logic [3:0]  cnt_mem [MAX_SETS];
    logic [16:0] off_mem [DEPTH];
    logic [31:0] val_mem [DEPTH];
    logic [3:0]  cnt_q;
    logic [16:0] off_q;
    logic [31:0] val_q;
    logic [AW-1:0] raddr;
    logic        mwe;
    logic [AW-1:0] waddr;

    bk_state_t   st_reg, st_next;
    cmd_t        cmd_reg;
    logic [CW-1:0] sets_reg;
    logic [CW-1:0] j_reg;
    logic [3:0]  k_reg;
    logic        same_reg;
    logic [CW-1:0] sel_idx;
    logic [31:0] cells_reg [CELLS];
    logic [3:0]  pos_reg;
    logic        out_full;
    logic [SW-1:0] emit_idx;
    logic        emit_new;
    logic [1:0]  emit_st;
    logic [AW-1:0] base;
    logic [3:0]  rd_cnt;
    logic        out_ld;
    res_t        res_reg, res_next;

    // readout offset split
    logic signed [18:0] o_s, x_s, s_s, r;
    logic        hit;
    logic [3:0]  cell_idx;

    assign busy = (st_reg != BK_IDLE);
    assign rd_idx = k_reg;
    assign sel_idx = cmd_reg.is_readout ? CW'(cmd_reg.sel) : j_reg;
    assign base = AW'(sel_idx[SW-1:0]) * AW'(ENTRIES);
    assign raddr = base + AW'(k_reg);
    assign mwe = (st_reg == BK_STORE) && (sets_reg < CW'(MAX_SETS));
    assign waddr = AW'(sets_reg[SW-1:0]) * AW'(ENTRIES) + AW'(k_reg);
    // a set that is not stored reads as empty
    assign rd_cnt = (int'(cmd_reg.sel) < int'(sets_reg)) ? cnt_q : 4'd0;
    // load the output register when it is free or being drained
    assign out_ld = ((st_reg == BK_EMIT) || (st_reg == BK_CELL)) && (!out_full || res_pop);

    always_ff @(posedge clk)
    begin
        if (mwe && k_reg < cmd_reg.fill[3:0])
        begin
            off_mem[waddr] <= rd_off;
            val_mem[waddr] <= rd_val;
        end
        if (mwe && k_reg == 4'd0)
            cnt_mem[sets_reg[SW-1:0]] <= cmd_reg.fill[3:0];
        off_q <= off_mem[raddr];
        val_q <= val_mem[raddr];
        cnt_q <= cnt_mem[sel_idx[SW-1:0]];
    end

    // split offset into x and y; x moves by one stride per step (|x| <= 2 matters)
    always_comb
    begin
        s_s = (column_stride == '0) ? 19'sd1 : 19'($signed({2'b0, column_stride}));
        o_s = 19'($signed(off_q));
        x_s = '0;
        hit = 1'b0;
        cell_idx = '0;
        r = o_s;
        if (o_s < -19'sd2)
        begin
            if (o_s + s_s >= -19'sd2)
            begin
                x_s = -19'sd1; r = o_s + s_s;
            end
            else
            begin
                x_s = -19'sd2; r = o_s + s_s + s_s;
            end
        end
        else if (o_s > 19'sd2)
        begin
            if (o_s - s_s <= 19'sd2)
            begin
                x_s = 19'sd1; r = o_s - s_s;
            end
            else
            begin
                x_s = 19'sd2; r = o_s - s_s - s_s;
            end
        end
        // x of two or more steps: only exactly two counts, and that needs range check
        if (x_s == -19'sd2)
        begin
            hit = (o_s + s_s + s_s >= -19'sd2) || 1'b0;
            hit = hit && (o_s + s_s + s_s + s_s > 19'sd2 || 1'b1) &&
                  (o_s + s_s + s_s >= -19'sd2);
            cell_idx = 4'd0;
        end
        else if (x_s == 19'sd2)
        begin
            hit = (o_s - s_s - s_s <= 19'sd2);
            cell_idx = 4'd12;
        end
        else if (x_s != 0)
        begin
            hit = (r >= -19'sd1) && (r <= 19'sd1);
            cell_idx = 4'((x_s < 0 ? 19'sd2 : 19'sd10) + r);
        end
        else
        begin
            hit = 1'b1;
            cell_idx = 4'(19'sd6 + r);
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE:
                if (cmd_valid && !clear)
                    st_next = cmd.is_readout ? BK_READ : (cmd.err ? BK_EMIT : BK_SEARCH);
            BK_SEARCH:
                st_next = (j_reg >= sets_reg) ? BK_STORE : BK_WAIT;
            BK_WAIT:
                st_next = BK_COMPARE;
            BK_COMPARE:
                if (!same_reg || cnt_q != cmd_reg.fill[3:0] ||
                    (k_reg < cmd_reg.fill[3:0] && (off_q != rd_off || val_q != rd_val)))
                    st_next = BK_SEARCH;
                else if (k_reg + 4'd1 >= cmd_reg.fill[3:0] || cmd_reg.fill == '0)
                    st_next = BK_EMIT;
                else
                    st_next = BK_WAIT;
            BK_STORE:
                if (sets_reg >= CW'(MAX_SETS) || k_reg + 4'd1 >= 4'(ENTRIES))
                    st_next = BK_EMIT;
            BK_EMIT:
                if (out_ld)
                    st_next = BK_IDLE;
            BK_READ:
                st_next = (k_reg >= rd_cnt && k_reg != 4'd0) ? BK_CELL : BK_READ;
            BK_CELL:
                if (out_ld && pos_reg == 4'(CELLS - 1))
                    st_next = BK_IDLE;
            default:
                st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && cmd_valid)
            cmd_reg <= cmd;
        if (st_reg == BK_READ && k_reg == 4'd0)
        begin
            for (int i = 0; i < CELLS; i++)
                cells_reg[i] <= '0;
        end
        else if (st_reg == BK_READ && k_reg != 4'd0 && (k_reg - 4'd1) < rd_cnt && hit)
            cells_reg[cell_idx] <= val_q;
    end

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            sets_reg <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            same_reg <= 1'b0;
            pos_reg  <= '0;
            out_full <= 1'b0;
            res_reg  <= '0;
            emit_idx <= '0;
            emit_new <= 1'b0;
            emit_st  <= ST_OK;
        end
        else
        begin
            st_reg <= st_next;
            out_full <= out_ld || (out_full && !res_pop);
            if (out_ld)
                res_reg <= res_next;
            if (clear)
                sets_reg <= '0;
            unique case (st_reg)
                BK_IDLE:
                begin
                    j_reg <= '0;
                    k_reg <= '0;
                    pos_reg <= '0;
                    same_reg <= 1'b1;
                    emit_st <= cmd.err ? cmd.err_code : ST_OK;
                    emit_idx <= '0;
                    emit_new <= 1'b0;
                end
                BK_SEARCH:
                begin
                    k_reg <= '0;
                    same_reg <= 1'b1;
                    if (j_reg >= sets_reg && sets_reg >= CW'(MAX_SETS))
                        emit_st <= ST_FULL;
                end
                BK_WAIT: ;
                BK_COMPARE:
                begin
                    if (st_next == BK_SEARCH)
                        j_reg <= j_reg + 1'b1;
                    else if (st_next == BK_EMIT)
                        emit_idx <= j_reg[SW-1:0];
                    else
                        k_reg <= k_reg + 4'd1;
                end
                BK_STORE:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (st_next == BK_EMIT && sets_reg < CW'(MAX_SETS))
                    begin
                        emit_idx <= sets_reg[SW-1:0];
                        emit_new <= 1'b1;
                        sets_reg <= sets_reg + 1'b1;
                    end
                end
                BK_EMIT: ;
                BK_READ:
                    k_reg <= k_reg + 4'd1;
                BK_CELL:
                    if (out_ld)
                        pos_reg <= pos_reg + 4'd1;
                default: ;
            endcase
        end
    end

    assign set_err = (st_reg == BK_EMIT) && (emit_st != ST_OK) && (cmd_reg.err_code == ST_OK
                     || cmd_reg.err);
    assign set_err_code = emit_st;
    assign res_valid = out_full;
    assign res = res_reg;

    // build the next transaction for the output register
    always_comb
    begin
        res_next = '0;
        res_next.sets_in_use = 9'(sets_reg);
        if (st_reg == BK_CELL)
        begin
            res_next.kind = 1'b1;
            res_next.set_index = cmd_reg.sel;
            res_next.status = cmd_reg.err_code;
            res_next.position = pos_reg;
            res_next.value = cells_reg[pos_reg];
            res_next.last = (pos_reg == 4'(CELLS - 1));
        end
        else
        begin
            res_next.set_index = 8'(emit_idx);
            res_next.new_set = emit_new;
            res_next.status = emit_st;
            res_next.last = 1'b1;
        end
    end

    `SRDI_ASSERT(a_cnt, clk, rst_n, sets_reg <= CW'(MAX_SETS), "set count overflow")
    `SRDI_ASSERT_NEXT(a_emit, clk, rst_n, st_reg == BK_EMIT, out_full, "result not queued")
    `SRDI_ASSERT(a_busy, clk, rst_n, !(cmd_valid && busy), "command while busy")
endmodule

@@ rtl/core/stencil_row_dedup_indexer_unit.sv @@
// Stencil row deduplicating indexer: entries of a sparse matrix arrive in row
// order; each finished row is matched against stored sets and appended when new
// and the set store has room. A row end walks the stored sets in order, comparing
// the count and then each entry; a rejected set moves the search to the next one,
// a matching set is emitted, and a new set is stored entry by entry and emitted.
// A readout first builds the cells from the stored entries, then hands out one cell
// per cycle while the output register is free or being drained. full stays high
// while the back end works; a finished result waits in an output register, so the
// next transaction can be taken while it waits.
// Depends on srdi_pkg, srdi_front, srdi_back.
`timescale 1ns / 1ps
module stencil_row_dedup_indexer_unit #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_POINTS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [16:0]        cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         operation,
    input  logic [15:0]        column_index,
    input  logic signed [31:0] coefficient,
    input  logic               entry_present,
    input  logic               row_end,
    input  logic [7:0]         set_select,
    output logic               empty,
    input  logic               pop,
    output logic               result_kind,
    output logic [7:0]         set_index,
    output logic               new_set,
    output logic [1:0]         status,
    output logic [8:0]         sets_in_use,
    output logic [3:0]         stencil_position,
    output logic signed [31:0] stencil_value,
    output logic               last
);
    import srdi_pkg::*;

    logic [16:0] stride_reg;
    logic        back_busy, cmd_valid, clear, set_err, res_valid;
    cmd_t        cmd;
    res_t        res;
    logic [1:0]  set_err_code;
    logic [3:0]  rd_idx;
    logic [16:0] rd_off;
    logic [31:0] rd_val;

    // hold the stride register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= 17'd2;
        else if (cfg_we)
            stride_reg <= cfg_wdata;
    end

    srdi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk, .rst_n, .push, .full, .operation, .column_index, .coefficient,
        .entry_present, .row_end, .set_select, .back_busy, .cmd_valid, .cmd,
        .clear, .set_err, .set_err_code, .rd_idx, .rd_off, .rd_val
    );

    srdi_back #(.MAX_SETS(MAX_SETS)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd, .clear, .busy(back_busy), .set_err,
        .set_err_code, .rd_idx, .rd_off, .rd_val, .column_stride(stride_reg),
        .res_valid, .res, .res_pop(pop)
    );

    assign empty = !res_valid;
    assign result_kind = res.kind;
    assign set_index = res.set_index;
    assign new_set = res.new_set;
    assign status = res.status;
    assign sets_in_use = res.sets_in_use;
    assign stencil_position = res.position;
    assign stencil_value = res.value;
    assign last = res.last;
endmodule
